[design/bktc_pkg.sv]
package bktc_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned KeyWidth    = 64;
  localparam int unsigned CountWidth  = 7;

  typedef enum logic [1:0] {
    CmdQuery  = 2'd0,
    CmdAdd    = 2'd1,
    CmdRemove = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                  command;
    logic [KeyWidth-1:0]   key;
  } in_item_t;

  typedef struct packed {
    logic                  found;
    logic                  accepted;
    logic [CountWidth-1:0] removed_count;
    logic [CountWidth-1:0] entry_count;
  } out_item_t;

endpackage

[design/bktc_mem.sv]
module bktc_mem import bktc_pkg::*; #(
  parameter int unsigned Depth = DefCapacity,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  logic [KeyWidth-1:0] wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output logic [KeyWidth-1:0] rdata_o
);

  logic [KeyWidth-1:0] mem_q [Depth];
  logic [KeyWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/bktc_ctrl.sv]
module bktc_ctrl import bktc_pkg::*; #(
  parameter int unsigned Capacity = DefCapacity,
  parameter int unsigned AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1,
  parameter int unsigned CntW     = $clog2(Capacity + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  output logic                mem_we_o,
  output logic [AddrW-1:0]    mem_waddr_o,
  output logic [KeyWidth-1:0] mem_wdata_o,
  output logic [AddrW-1:0]    mem_raddr_o,
  input  logic [KeyWidth-1:0] mem_rdata_i
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  state_e              state_q, state_d;
  cmd_e                cmd_q, cmd_d;
  logic [KeyWidth-1:0] key_q, key_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     rd_q, rd_d;
  logic [CntW-1:0]     wr_q, wr_d;
  logic [CntW-1:0]     gone_q, gone_d;
  logic                pend_q, pend_d;
  logic                hit_q, hit_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;
  logic [CntW-1:0]     new_cnt;

  always_comb begin
    unique case (cmd_q)
      CmdRemove: new_cnt = wr_q;
      CmdAdd:    new_cnt = hit_q ? cnt_q + CntW'(1) : cnt_q;
      default:   new_cnt = cnt_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    gone_d      = gone_q;
    pend_d      = pend_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_q[AddrW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = rd_q[AddrW-1:0];
    in_stall_o  = (state_q != StIdle);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_d  = in_data_i.command;
          key_d  = in_data_i.key;
          rd_d   = '0;
          wr_d   = '0;
          gone_d = '0;
          pend_d = 1'b0;
          hit_d  = 1'b0;
          unique case (in_data_i.command)
            CmdQuery, CmdRemove: begin
              state_d = (cnt_q == '0) ? StFinish : StScan;
            end
            CmdAdd: begin
              if (cnt_q < CntW'(Capacity)) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = cnt_q[AddrW-1:0];
                mem_wdata_o = in_data_i.key;
                hit_d       = 1'b1;
              end
              state_d = StFinish;
            end
            default: state_d = StFinish;
          endcase
        end
      end
      StScan: begin
        if (rd_q < cnt_q) begin
          rd_d   = rd_q + CntW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (mem_rdata_i == key_q) begin
            hit_d  = 1'b1;
            gone_d = gone_q + CntW'(1);
          end else begin
            wr_d     = wr_q + CntW'(1);
            mem_we_o = (cmd_q == CmdRemove);
          end
          if (rd_q == cnt_q) begin
            state_d = StFinish;
          end
        end
      end
      StFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_d.found         = (cmd_q == CmdQuery) && hit_q;
          out_d.accepted      = (cmd_q == CmdAdd) && hit_q;
          out_d.removed_count = (cmd_q == CmdRemove) ? CountWidth'(gone_q) : '0;
          out_d.entry_count   = CountWidth'(new_cnt);
          cnt_d               = new_cnt;
          state_d             = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cmd_q       <= CmdQuery;
      key_q       <= '0;
      cnt_q       <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      gone_q      <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      key_q       <= key_d;
      cnt_q       <= cnt_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      gone_q      <= gone_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/bounded_key_table_with_compaction_unit.sv]
// Ordered table of up to Capacity 64-bit keys held in one single-port-write,
// registered-read memory. Each transaction carries a command and a key and
// yields one result: query reports membership, add appends the key when the
// table is not full (duplicates allowed), remove deletes every copy and closes
// the gaps in place while keeping the order, and every result carries the new
// entry count. Add and the unused command go from acceptance straight to the
// result; query and remove first walk the stored entries through the memory
// read port one per cycle (no walk on an empty table).
// One transaction is in work at a time; the result sits in an output register,
// so the next transaction is accepted while an earlier result is still stalled.
module bounded_key_table_with_compaction_unit import bktc_pkg::*; #(
  parameter int unsigned Capacity = DefCapacity
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW  = $clog2(Capacity + 1);

  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  logic [KeyWidth-1:0] mem_wdata;
  logic [AddrW-1:0]    mem_raddr;
  logic [KeyWidth-1:0] mem_rdata;

  bktc_ctrl #(
    .Capacity (Capacity),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  bktc_mem #(
    .Depth (Capacity),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

[bench/bounded_key_table_with_compaction_unit_tb.sv]
`timescale 1ns / 1ps

class key_table_scoreboard;
  int unsigned capacity;
  logic [bktc_pkg::KeyWidth-1:0] stored_keys[$];
  bktc_pkg::out_item_t awaited_results[$];
  int unsigned mismatches;

  function new(int unsigned cap);
    capacity = cap;
    mismatches = 0;
  endfunction

  function int unsigned outstanding();
    return awaited_results.size();
  endfunction

  // table behavior for one accepted transaction
  function void note_command(bktc_pkg::in_item_t item);
    bktc_pkg::out_item_t res;
    int unsigned hits;
    int unsigned held;
    res = '0;
    hits = 0;
    case (item.command)
      bktc_pkg::CmdQuery: begin
        foreach (stored_keys[i]) begin
          if (stored_keys[i] == item.key) res.found = 1'b1;
        end
      end
      bktc_pkg::CmdAdd: begin
        if (stored_keys.size() < capacity) begin
          stored_keys.push_back(item.key);
          res.accepted = 1'b1;
        end
      end
      bktc_pkg::CmdRemove: begin
        for (int i = stored_keys.size() - 1; i >= 0; i--) begin
          if (stored_keys[i] == item.key) begin
            stored_keys.delete(i);
            hits++;
          end
        end
      end
      default: begin
      end
    endcase
    held = stored_keys.size();
    res.removed_count = hits[bktc_pkg::CountWidth-1:0];
    res.entry_count = held[bktc_pkg::CountWidth-1:0];
    awaited_results.push_back(res);
  endfunction

  function void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    end
  endfunction

  function void check_result(bktc_pkg::out_item_t got);
    bktc_pkg::out_item_t want;
    if (awaited_results.size() == 0) begin
      mismatches++;
      $display("%0t: result %h expected nothing", $time, got);
      return;
    end
    want = awaited_results.pop_front();
    if ($isunknown(got)) begin
      mismatches++;
      $display("%0t: result expected %h got %h", $time, want, got);
      return;
    end
    compare_field("found", 32'(want.found), 32'(got.found));
    compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
    compare_field("removed_count", 32'(want.removed_count), 32'(got.removed_count));
    compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
  endfunction
endclass

module bounded_key_table_with_compaction_unit_tb;
  import bktc_pkg::*;

  localparam int unsigned Capacity = DefCapacity;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned ItemsPerPhase = 460;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic [KeyWidth-1:0] KeyZero = '0;
  localparam logic [KeyWidth-1:0] KeyOnes = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  logic [KeyWidth-1:0] key_pool[8];

  key_table_scoreboard sb = new(Capacity);

  bounded_key_table_with_compaction_unit #(
    .Capacity(Capacity)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) sb.note_command(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [KeyWidth-1:0] fresh_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [KeyWidth-1:0] pool_key();
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, 7)];
    return fresh_key();
  endfunction

  function automatic void refresh_pool(int unsigned slots);
    int unsigned roll;
    repeat (slots) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) key_pool[$urandom_range(0, 7)] = KeyZero;
      else if (roll == 1) key_pool[$urandom_range(0, 7)] = KeyOnes;
      else key_pool[$urandom_range(0, 7)] = fresh_key();
    end
  endfunction

  // one transaction, held until the block takes it
  task automatic drive_item(logic [1:0] cmd, logic [KeyWidth-1:0] key);
    in_item_t item;
    item.command = cmd_e'(cmd);
    item.key = key;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    drive_item(CmdQuery, KeyZero);
    drive_item(CmdRemove, KeyOnes);
    drive_item(CmdAdd, KeyZero);
    drive_item(CmdAdd, KeyOnes);
    drive_item(CmdAdd, 64'h5555_5555_5555_5555);
    drive_item(CmdAdd, KeyOnes);
    drive_item(CmdAdd, 64'hAAAA_AAAA_AAAA_AAAA);
    drive_item(CmdUnused, KeyOnes);
    drive_item(CmdQuery, KeyZero);
    drive_item(CmdQuery, KeyOnes);
    drive_item(CmdQuery, 64'h0123_4567_89AB_CDEF);
    drive_item(CmdRemove, KeyOnes);
    drive_item(CmdQuery, KeyOnes);
    drive_item(CmdRemove, KeyZero);
    drive_item(CmdQuery, 64'hAAAA_AAAA_AAAA_AAAA);
    drive_item(CmdQuery, 64'h5555_5555_5555_5555);
    drive_item(CmdRemove, 64'h0000_0000_0000_1234);
    drive_item(CmdAdd, 64'h8000_0000_0000_0001);
    drive_item(CmdRemove, 64'h5555_5555_5555_5555);
    drive_item(CmdQuery, 64'h8000_0000_0000_0001);
    drive_item(CmdUnused, KeyZero);
    drive_item(CmdRemove, 64'hAAAA_AAAA_AAAA_AAAA);
    drive_item(CmdRemove, 64'h8000_0000_0000_0001);
    drive_item(CmdQuery, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  // segments that fill, drain or churn the table
  task automatic run_random(int unsigned count);
    int unsigned left;
    int unsigned seg;
    int unsigned mode;
    int unsigned roll;
    int unsigned add_lim;
    int unsigned query_lim;
    int unsigned remove_lim;
    left = count;
    while (left > 0) begin
      seg = $urandom_range(20, 80);
      mode = $urandom_range(0, 2);
      refresh_pool(2);
      case (mode)
        0: begin
          add_lim = 80; query_lim = 92; remove_lim = 97;
        end
        1: begin
          add_lim = 25; query_lim = 50; remove_lim = 96;
        end
        default: begin
          add_lim = 45; query_lim = 75; remove_lim = 96;
        end
      endcase
      while (seg > 0 && left > 0) begin
        roll = $urandom_range(0, 99);
        if (roll < add_lim) begin
          drive_item(CmdAdd, pool_key());
        end else if (roll < query_lim) begin
          drive_item(CmdQuery, pool_key());
        end else if (roll < remove_lim) begin
          drive_item(CmdRemove, (mode == 0) ? fresh_key() : pool_key());
        end else begin
          drive_item(CmdUnused, fresh_key());
          continue;
        end
        seg--;
        left--;
      end
    end
  endtask

  initial begin
    refresh_pool(16);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_directed();
    run_random(ItemsPerPhase);
    wait_drained();

    send_idle_pct = 57;
    recv_stall_pct = 0;
    run_random(ItemsPerPhase);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 57;
    run_random(ItemsPerPhase);
    wait_drained();

    send_idle_pct = 12;
    recv_stall_pct = 12;
    run_random(ItemsPerPhase);
    wait_drained();

    repeat (Capacity + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
